### sv/column_minmax_decimator_unit_assert.svh
// Assertion macros for the column min/max decimator.
`ifndef COLUMN_MINMAX_DECIMATOR_UNIT_ASSERT_SVH
`define COLUMN_MINMAX_DECIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, held off during rst.
`define CMMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, held off during rst.
`define CMMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cmmd_pkg.sv
// Shared types and constants for the column min/max decimator.
`timescale 1ns / 1ps
package cmmd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int FIFO_DEPTH  = 4;
  localparam int KEPT_W      = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_MIN        = 3'd0,
    REG_X_MAX        = 3'd1,
    REG_COLUMN_SCALE = 3'd2,
    REG_COLUMN_COUNT = 3'd3,
    REG_SAMPLE_COUNT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] x_max;
    logic [31:0]        column_scale;
    logic [12:0]        column_count;
    logic [16:0]        sample_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    x_min:        32'sd0,
    x_max:        32'sd65536,
    column_scale: 32'd65536,
    column_count: 13'd1024,
    sample_count: 17'd0
  };

  // saturation limits of the column number
  localparam logic signed [31:0] COL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### sv/cmmd_if.sv
// Channel interfaces: incoming samples and kept indices.
`timescale 1ns / 1ps
interface cmmd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic               is_gap;
  logic               last_sample;

  modport source (output valid, output x_value, output y_value, output is_gap,
                  output last_sample, input ready);
  modport sink (input valid, input x_value, input y_value, input is_gap,
                input last_sample, output ready);
endinterface

interface cmmd_kept_if;
  logic        valid;
  logic        ready;
  logic [15:0] kept_index;
  logic        run_last;

  modport source (output valid, output kept_index, output run_last, input ready);
  modport sink (input valid, input kept_index, input run_last, output ready);
endinterface

### sv/cmmd_fifo.sv
// Small register queue of run descriptors between front and back.
`timescale 1ns / 1ps
module cmmd_fifo import cmmd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output fifo_stat_t       stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign pop_data   = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/cmmd_front.sv
// Front: column mapping pipeline and run tracking, emits run descriptors.
`timescale 1ns / 1ps
module cmmd_front import cmmd_pkg::*; #(
  parameter int MAX_SAMPLES = 65536,
  localparam int IDX_W = $clog2(MAX_SAMPLES),
  localparam int DESC_W = 5 * IDX_W + 2
) (
  input  logic              clk,
  input  logic              rst,
  cmmd_sample_if.sink       samples,
  input  cfg_t              cfg,
  input  fifo_stat_t        fstat,
  output logic              push,
  output logic [DESC_W-1:0] push_data
);

  typedef struct packed {
    logic             run_valid;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] low_idx;
    logic [IDX_W-1:0] high_idx;
    logic [IDX_W-1:0] latest_idx;
    logic             tail_valid;
    logic [IDX_W-1:0] tail_idx;
  } desc_t;

  logic advance;
  logic take;
  logic need_push;

  // stage a: offset from x_min
  logic               a_valid;
  logic               a_neg;
  logic [31:0]        a_mag;
  logic signed [31:0] a_y;
  logic               a_gap, a_last, a_pass;
  // stage b: scaled product
  logic               b_valid;
  logic               b_neg;
  logic [63:0]        b_prod;
  logic signed [31:0] b_y;
  logic               b_gap, b_last, b_pass;
  // stage c: saturated column
  logic               c_valid;
  logic signed [31:0] c_col;
  logic signed [31:0] c_y;
  logic               c_gap, c_last, c_pass;

  logic signed [32:0] diff;
  logic signed [32:0] diff_neg;
  logic               pass;
  logic [63:0]        prod;
  logic [31:0]        q;
  logic signed [31:0] col;

  // run state
  logic [IDX_W-1:0]   counter, counter_next;
  logic               column_open, column_open_next;
  logic signed [31:0] current_column, current_column_next;
  logic [IDX_W-1:0]   first_index, first_index_next;
  logic [IDX_W-1:0]   latest_index, latest_index_next;
  logic [IDX_W-1:0]   low_index, low_index_next;
  logic [IDX_W-1:0]   high_index, high_index_next;
  logic signed [31:0] low_y, low_y_next;
  logic signed [31:0] high_y, high_y_next;
  desc_t              desc;

  // the pipe holds while stage c has a descriptor that the queue cannot take
  assign advance       = !(need_push && fstat.full);
  assign samples.ready = advance;
  assign take          = samples.valid && advance;

  assign diff     = $signed({samples.x_value[31], samples.x_value})
                  - $signed({cfg.x_min[31], cfg.x_min});
  assign diff_neg = -diff;
  assign pass     = (cfg.column_count < 13'd2)
                 || (cfg.sample_count <= {2'b00, cfg.column_count, 2'b00})
                 || !($signed(cfg.x_max) > $signed(cfg.x_min));
  assign prod     = a_mag * cfg.column_scale;
  assign q        = b_prod[63:32];

  always_comb begin
    if (b_neg) begin
      col = q[31] ? COL_MIN : $signed(32'd0 - q);
    end else begin
      col = q[31] ? COL_MAX : $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= take;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_neg  <= diff[32];
      a_mag  <= diff[32] ? diff_neg[31:0] : diff[31:0];
      a_y    <= samples.y_value;
      a_gap  <= samples.is_gap;
      a_last <= samples.last_sample;
      a_pass <= pass;
      b_neg  <= a_neg;
      b_prod <= prod;
      b_y    <= a_y;
      b_gap  <= a_gap;
      b_last <= a_last;
      b_pass <= a_pass;
      c_col  <= col;
      c_y    <= b_y;
      c_gap  <= b_gap;
      c_last <= b_last;
      c_pass <= b_pass;
    end
  end

  // classification against the open run
  always_comb begin
    desc                = '0;
    column_open_next    = column_open;
    current_column_next = current_column;
    first_index_next    = first_index;
    latest_index_next   = latest_index;
    low_index_next      = low_index;
    high_index_next     = high_index;
    low_y_next          = low_y;
    high_y_next         = high_y;
    desc.first_idx      = first_index;
    desc.low_idx        = low_index;
    desc.high_idx       = high_index;
    desc.latest_idx     = latest_index;
    desc.tail_idx       = counter;
    if (c_pass || c_gap) begin
      desc.run_valid   = column_open;
      desc.tail_valid  = 1'b1;
      column_open_next = 1'b0;
    end else if (!column_open || (c_col != current_column)) begin
      desc.run_valid      = column_open;
      current_column_next = c_col;
      first_index_next    = counter;
      latest_index_next   = counter;
      low_index_next      = counter;
      high_index_next     = counter;
      low_y_next          = c_y;
      high_y_next         = c_y;
      column_open_next    = !c_last;
      // a run opened and closed by the last sample is just this index
      desc.tail_valid     = c_last;
    end else begin
      latest_index_next = counter;
      if (c_y < low_y) begin
        low_y_next     = c_y;
        low_index_next = counter;
      end
      if (c_y > high_y) begin
        high_y_next     = c_y;
        high_index_next = counter;
      end
      if (c_last) begin
        desc.run_valid   = 1'b1;
        desc.low_idx     = low_index_next;
        desc.high_idx    = high_index_next;
        desc.latest_idx  = counter;
        column_open_next = 1'b0;
      end
    end
    need_push = c_valid && (desc.run_valid || desc.tail_valid);
    push      = need_push && !fstat.full;
    if (c_last || (counter == IDX_W'(MAX_SAMPLES - 1))) begin
      counter_next = '0;
    end else begin
      counter_next = counter + 1'b1;
    end
  end

  assign push_data = desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter        <= '0;
      column_open    <= 1'b0;
      current_column <= '0;
    end else if (c_valid && advance) begin
      counter        <= counter_next;
      column_open    <= column_open_next;
      current_column <= current_column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid && advance) begin
      first_index  <= first_index_next;
      latest_index <= latest_index_next;
      low_index    <= low_index_next;
      high_index   <= high_index_next;
      low_y        <= low_y_next;
      high_y       <= high_y_next;
    end
  end

endmodule

### sv/cmmd_back.sv
// Back: sorts a run descriptor, drops duplicates and sends indices out one by one.
`timescale 1ns / 1ps
module cmmd_back import cmmd_pkg::*; #(
  parameter int MAX_SAMPLES = 65536,
  localparam int IDX_W = $clog2(MAX_SAMPLES),
  localparam int DESC_W = 5 * IDX_W + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  fifo_stat_t        fstat,
  input  logic [DESC_W-1:0] head,
  output logic              pop,
  cmmd_kept_if.source       kept
);

  typedef struct packed {
    logic             run_valid;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] low_idx;
    logic [IDX_W-1:0] high_idx;
    logic [IDX_W-1:0] latest_idx;
    logic             tail_valid;
    logic [IDX_W-1:0] tail_idx;
  } desc_t;

  desc_t            hd;
  logic [IDX_W-1:0] t0 [4];
  logic [IDX_W-1:0] t1 [4];
  logic [IDX_W-1:0] srt [4];
  logic [4:0]       keep;

  logic [IDX_W-1:0] slot [5];
  logic [4:0]       mask;
  logic [4:0]       pick;
  logic [4:0]       rest;
  logic [IDX_W-1:0] word;
  logic             emit;

  assign hd = head;

  // five compare-exchanges in three layers
  always_comb begin
    t0[0] = (hd.first_idx < hd.low_idx) ? hd.first_idx : hd.low_idx;
    t0[1] = (hd.first_idx < hd.low_idx) ? hd.low_idx : hd.first_idx;
    t0[2] = (hd.high_idx < hd.latest_idx) ? hd.high_idx : hd.latest_idx;
    t0[3] = (hd.high_idx < hd.latest_idx) ? hd.latest_idx : hd.high_idx;
    t1[0] = (t0[0] < t0[2]) ? t0[0] : t0[2];
    t1[2] = (t0[0] < t0[2]) ? t0[2] : t0[0];
    t1[1] = (t0[1] < t0[3]) ? t0[1] : t0[3];
    t1[3] = (t0[1] < t0[3]) ? t0[3] : t0[1];
    srt[0] = t1[0];
    srt[1] = (t1[1] < t1[2]) ? t1[1] : t1[2];
    srt[2] = (t1[1] < t1[2]) ? t1[2] : t1[1];
    srt[3] = t1[3];
    keep[0] = hd.run_valid;
    keep[1] = hd.run_valid && (srt[1] != srt[0]);
    keep[2] = hd.run_valid && (srt[2] != srt[1]);
    keep[3] = hd.run_valid && (srt[3] != srt[2]);
    keep[4] = hd.tail_valid;
  end

  // lowest pending slot goes next
  assign pick = mask & (~mask + 5'd1);
  assign rest = mask & ~pick;
  assign emit = (mask != '0) && (!kept.valid || kept.ready);
  assign pop  = !fstat.empty && ((mask == '0) || (emit && (rest == '0)));

  always_comb begin
    word = '0;
    for (int i = 0; i < 5; i++) begin
      if (pick[i]) begin
        word = word | slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= '0;
      kept.valid <= 1'b0;
    end else begin
      if (pop) begin
        mask <= keep;
      end else if (emit) begin
        mask <= rest;
      end
      if (emit) begin
        kept.valid <= 1'b1;
      end else if (kept.ready) begin
        kept.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot[0] <= srt[0];
      slot[1] <= srt[1];
      slot[2] <= srt[2];
      slot[3] <= srt[3];
      slot[4] <= hd.tail_idx;
    end
    if (emit) begin
      kept.kept_index <= KEPT_W'(word);
      kept.run_last   <= (rest == '0);
    end
  end

endmodule

### sv/column_minmax_decimator_unit.sv
// Column min/max decimator: top level with configuration registers.
`timescale 1ns / 1ps
// Usage
//   samples : sink channel, one (x_value, y_value, is_gap, last_sample) word per
//             handshake. Indices are counted from 0 and restart after last_sample.
//   kept    : source channel, one kept_index word per handshake; run_last marks
//             the final index produced by a given sample.
//   cfg_*   : write-only register port (x_min, x_max, column_scale, column_count,
//             sample_count); write only while the block holds no pending work.
// Timing
//   A sample is taken every cycle while the descriptor queue has room. The front
//   is a three-stage pipe (offset, 32x32 scale multiply, saturation) followed by
//   run classification; a run-closing sample passes the pipe, the queue and the
//   back's registers before its first index shows on kept. The back sends one
//   index per cycle while kept is ready, so a run close gives up to five indices;
//   a four-deep queue absorbs them; sustained rate is output-bound at one word/cycle.
// Reset (rst, synchronous): config returns to defaults, no run is open, index
//   counter goes to 0, queue and output register empty.
// Stall: a stalled receiver holds the output word, the back stops, the queue
//   fills, and samples.ready drops only once the queue is full.
module column_minmax_decimator_unit import cmmd_pkg::*; #(
  parameter int MAX_SAMPLES = 65536,
  parameter int MAX_COLUMNS = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  cmmd_sample_if.sink            samples,
  cmmd_kept_if.source            kept,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int DESC_W = 5 * IDX_W + 2;

  cfg_t              cfg;
  fifo_stat_t        fifo_stat;
  logic              fifo_push;
  logic              fifo_pop;
  logic [DESC_W-1:0] fifo_in;
  logic [DESC_W-1:0] fifo_head;

  // register file; column and sample counts saturate on write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_MIN:        cfg.x_min <= $signed(cfg_data);
        REG_X_MAX:        cfg.x_max <= $signed(cfg_data);
        REG_COLUMN_SCALE: cfg.column_scale <= cfg_data;
        REG_COLUMN_COUNT: begin
          if ({19'd0, cfg_data[12:0]} > 32'(MAX_COLUMNS)) begin
            cfg.column_count <= 13'(MAX_COLUMNS);
          end else begin
            cfg.column_count <= cfg_data[12:0];
          end
        end
        REG_SAMPLE_COUNT: begin
          if ({15'd0, cfg_data[16:0]} > 32'(MAX_SAMPLES)) begin
            cfg.sample_count <= 17'(MAX_SAMPLES);
          end else begin
            cfg.sample_count <= cfg_data[16:0];
          end
        end
        default: cfg <= cfg;
      endcase
    end
  end

  // front: map to columns, track the open run, hand closed runs on
  cmmd_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg       (cfg),
    .fstat     (fifo_stat),
    .push      (fifo_push),
    .push_data (fifo_in)
  );

  cmmd_fifo #(.WIDTH(DESC_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (fifo_in),
    .pop       (fifo_pop),
    .pop_data  (fifo_head),
    .stat      (fifo_stat)
  );

  // back: sort, dedup, serialise
  cmmd_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk   (clk),
    .rst   (rst),
    .fstat (fifo_stat),
    .head  (fifo_head),
    .pop   (fifo_pop),
    .kept  (kept)
  );

`include "column_minmax_decimator_unit_assert.svh"

  `CMMD_ASSERT_NOW(a_no_overflow, fifo_push, !fifo_stat.full, "descriptor pushed into full queue")
  `CMMD_ASSERT_NOW(a_no_underflow, fifo_pop, !fifo_stat.empty, "descriptor popped from empty queue")
  `CMMD_ASSERT_NOW(a_stall_cause, !samples.ready, fifo_stat.full, "input stalled with queue room")
  `CMMD_ASSERT_NEXT(a_burst_on, kept.valid && kept.ready && !kept.run_last, kept.valid, "burst broken before run_last")

endmodule
